### rtl/nid_pkg.sv
// Shared types, sizes and status codes for the Neville interpolation unit.
// No dependencies; every other file imports this package.
`default_nettype none
package nid_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MAX_DERIV  = 4;
  localparam int NDER       = MAX_DERIV + 1;

  localparam int ROW_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int NS_W   = ROW_W + 2;
  localparam int K_W    = 3;
  localparam int TAB_AW = $clog2(MAX_POINTS * NDER);

  localparam int X_W   = 32;
  localparam int Q_W   = 48;
  localparam int NUM_W = Q_W + 1;
  localparam int DEN_W = X_W + 1;
  localparam int QUO_W = NUM_W + 16;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;
  localparam logic [1:0] STATUS_MANY = 2'd3;

  typedef struct packed {
    logic signed [X_W-1:0] x_offset;
    logic signed [X_W-1:0] y_sample;
    logic                  last_point;
  } in_item_t;

  typedef struct packed {
    logic [K_W-1:0]        deriv_index;
    logic signed [Q_W-1:0] result_value;
    logic [1:0]            status;
    logic                  last_result;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT_RD, ST_INIT_WB, ST_XA_RD, ST_XB_RD, ST_K_RD, ST_K_NUM,
    ST_DIV, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_QM, ST_WR,
    ST_ACC_SEL, ST_ACC_RD, ST_ACC_WB, ST_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/nid_div.sv
// Restoring divider, one quotient bit per cycle, for the tableau quotients.
// Depends on nid_pkg for widths and the request struct.
`default_nettype none
module nid_div (
  input  logic                     clk,
  input  logic                     rst,
  input  nid_pkg::div_req_t        req,
  output logic                     done,
  output logic [nid_pkg::QUO_W-1:0] quo
);
  import nid_pkg::*;

  localparam int CW = $clog2(QUO_W);

  logic [QUO_W-1:0] dvd;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   rem2;
  logic [DEN_W+1:0] diff;
  logic             qbit;

  always_comb begin
    rem2 = {rem, dvd[QUO_W-1]};
    diff = {1'b0, rem2} - {2'b0, den};
    qbit = ~diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= {req.num_mag, 16'b0};
      den <= req.den_mag;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[QUO_W-2:0], 1'b0};
      rem <= qbit ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

### rtl/neville_interpolation_with_derivatives_unit.sv
// Top level: point loading, Neville tableau sequencer with derivatives, result output.
// Depends on nid_pkg and nid_div.
// Loading accepts one point per cycle while in ST_LOAD. Each tableau entry uses the
// bit-serial divider and the shared 32x32 multiplier (4 products). A run of N points
// and order D computes each tableau column followed by an accumulation pass, then
// emits one result per cycle while out_stall is low. Reset is synchronous and clears the
// control state; the tableau memories need no clearing pass.
`default_nettype none
module neville_interpolation_with_derivatives_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nid_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nid_pkg::out_item_t   out_data,
  input  logic                 cfg_wr_en,
  input  logic [nid_pkg::K_W-1:0] cfg_wr_data
);
  import nid_pkg::*;

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [ROW_W-1:0] row,
                                                 input logic [K_W-1:0] kk);
    tab_addr = TAB_AW'(row) * TAB_AW'(NDER) + TAB_AW'(kk);
  endfunction

  function automatic logic [Q_W-1:0] from_mag(input logic [QUO_W-1:0] mv,
                                              input logic neg, output logic ov);
    ov = neg ? (mv > (QUO_W'(1) << (Q_W - 1))) : (mv[QUO_W-1:Q_W-1] != '0);
    if (ov) from_mag = neg ? Q_MIN : Q_MAX;
    else    from_mag = neg ? -mv[Q_W-1:0] : mv[Q_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [NS_W-1:0] v);
    clamp_row = ($unsigned(v) < NS_W'(MAX_POINTS)) ? v[ROW_W-1:0] : '0;
  endfunction

  state_t state, state_next;

  logic [X_W-1:0]          abs_mem [MAX_POINTS];
  logic [Q_W-1:0]          c_mem [MAX_POINTS*NDER];
  logic [Q_W-1:0]          d_mem [MAX_POINTS*NDER];
  logic [ROW_W-1:0]        abs_addr;
  logic [TAB_AW-1:0]       c_addr, d_addr;
  logic                    abs_we, tab_we;
  logic [Q_W-1:0]          c_wdata, d_wdata;
  logic signed [X_W-1:0]   abs_rd;
  logic signed [Q_W-1:0]   c_rd, d_rd;

  logic [K_W-1:0]          order_reg, nd, k, kmax;
  logic [CNT_W-1:0]        pts, m, i;
  logic [ROW_W-1:0]        nearest, n, j;
  logic [X_W-1:0]          near_mag;
  logic signed [NS_W-1:0]  ns;
  logic                    sel_c, neg, flag_many, flag_dup, flag_sat;
  logic signed [X_W-1:0]   dm, dp;
  logic signed [Q_W-1:0]   xq, xq_prev, qd, qc;
  logic [63:0]             prod, pd_lo, pd_hi, pm_lo, pm_hi;
  logic signed [Q_W-1:0]   acc [NDER];

  logic                    in_acc, out_free;
  logic [X_W-1:0]          x_mag, ua_p, ua_m, mul_a, mul_b;
  logic [Q_W-1:0]          ub;
  logic signed [NUM_W-1:0] num;
  logic signed [DEN_W-1:0] den;
  div_req_t                div_req;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;
  logic [Q_W-1:0]          xq_val, qd_val, qc_val;
  logic                    xq_ov, qd_ov, qc_ov;
  logic signed [50:0]      t;
  logic signed [51:0]      dd, cd;
  logic signed [Q_W-1:0]   d_val, c_val;
  logic                    wr_ov;
  logic signed [Q_W:0]     acc_sum;
  logic signed [Q_W-1:0]   acc_add;
  logic [1:0]              status;

  nid_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(div_quo));

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign x_mag    = in_data.x_offset[X_W-1] ? -in_data.x_offset : in_data.x_offset;
  assign ua_p     = dp[X_W-1] ? -dp : dp;
  assign ua_m     = dm[X_W-1] ? -dm : dm;
  assign ub       = xq[Q_W-1] ? -xq : xq;
  assign status   = flag_many ? STATUS_MANY : flag_dup ? STATUS_DUP :
                    flag_sat ? STATUS_SAT : STATUS_OK;

  always_comb begin
    num = (K_W'(0) + k == m[K_W-1:0] && m < CNT_W'(NDER)) ? '0 :
          NUM_W'(d_rd) - NUM_W'(c_rd);
    den = DEN_W'(dp) - DEN_W'(dm);
    div_req.start   = (state == ST_K_NUM) && (den != '0);
    div_req.num_mag = num[NUM_W-1] ? -num : num;
    div_req.den_mag = den[DEN_W-1] ? -den : den;
    xq_val = from_mag(div_quo, neg, xq_ov);
    qd_val = from_mag(QUO_W'((pd_hi << 16) + (pd_lo >> 16)), dp[X_W-1] ^ xq[Q_W-1], qd_ov);
    qc_val = from_mag(QUO_W'((pm_hi << 16) + (pm_lo >> 16)), dm[X_W-1] ^ xq[Q_W-1], qc_ov);
    t  = 51'(xq_prev) * {48'b0, k};
    dd = 52'(qd) - 52'(t);
    cd = 52'(qc) - 52'(t);
    wr_ov = 1'b0;
    if (k == '0) begin
      d_val = qd;
      c_val = qc;
    end else begin
      d_val = (dd[51:Q_W-1] == '0 || dd[51:Q_W-1] == '1) ? dd[Q_W-1:0] :
              (dd[51] ? Q_MIN : Q_MAX);
      c_val = (cd[51:Q_W-1] == '0 || cd[51:Q_W-1] == '1) ? cd[Q_W-1:0] :
              (cd[51] ? Q_MIN : Q_MAX);
      wr_ov = !(dd[51:Q_W-1] == '0 || dd[51:Q_W-1] == '1) ||
              !(cd[51:Q_W-1] == '0 || cd[51:Q_W-1] == '1);
    end
    acc_sum = (Q_W+1)'(acc[k]) + (Q_W+1)'(sel_c ? c_rd : d_rd);
    acc_add = (acc_sum[Q_W] == acc_sum[Q_W-1]) ? acc_sum[Q_W-1:0] :
              (acc_sum[Q_W] ? Q_MIN : Q_MAX);
  end

  always_comb begin
    mul_a = ua_p;
    mul_b = ub[31:0];
    case (state)
      ST_MUL1: mul_b = 32'(ub[Q_W-1:32]);
      ST_MUL2: mul_a = ua_m;
      ST_MUL3: begin
        mul_a = ua_m;
        mul_b = 32'(ub[Q_W-1:32]);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    abs_addr   = i[ROW_W-1:0];
    abs_we     = 1'b0;
    tab_we     = 1'b0;
    c_addr     = tab_addr(i[ROW_W-1:0], k);
    d_addr     = tab_addr(i[ROW_W-1:0], k);
    c_wdata    = c_val;
    d_wdata    = d_val;
    unique case (state)
      ST_LOAD: begin
        abs_addr = pts[ROW_W-1:0];
        c_addr   = tab_addr(pts[ROW_W-1:0], '0);
        d_addr   = tab_addr(pts[ROW_W-1:0], '0);
        c_wdata  = Q_W'(in_data.y_sample);
        d_wdata  = Q_W'(in_data.y_sample);
        abs_we   = in_acc && (pts < CNT_W'(MAX_POINTS));
        tab_we   = abs_we;
        if (in_acc && in_data.last_point) state_next = ST_INIT_RD;
      end
      ST_INIT_RD: begin
        c_addr     = tab_addr(nearest, '0);
        state_next = ST_INIT_WB;
      end
      ST_INIT_WB: state_next = (n == '0) ? ST_OUT : ST_XA_RD;
      ST_XA_RD:   state_next = ST_XB_RD;
      ST_XB_RD: begin
        abs_addr   = ROW_W'(i + m);
        state_next = ST_K_RD;
      end
      ST_K_RD: begin
        c_addr     = tab_addr(ROW_W'(i + 1'b1), k);
        state_next = ST_K_NUM;
      end
      ST_K_NUM:  state_next = (den == '0) ? ST_MUL0 : ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_MUL0;
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_MUL4;
      ST_MUL4:   state_next = ST_QM;
      ST_QM:     state_next = ST_WR;
      ST_WR: begin
        tab_we = 1'b1;
        if (k < kmax) state_next = ST_K_RD;
        else if (i + 1'b1 + m <= CNT_W'(n)) state_next = ST_XA_RD;
        else state_next = ST_ACC_SEL;
      end
      ST_ACC_SEL: state_next = ST_ACC_RD;
      ST_ACC_RD: begin
        c_addr     = tab_addr(j, k);
        d_addr     = tab_addr(j, k);
        state_next = ST_ACC_WB;
      end
      ST_ACC_WB: begin
        if (k < kmax) state_next = ST_ACC_RD;
        else if (m < CNT_W'(n)) state_next = ST_XA_RD;
        else state_next = ST_OUT;
      end
      ST_OUT: if (out_free && k == nd) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (abs_we) abs_mem[abs_addr] <= in_data.x_offset;
    abs_rd <= abs_mem[abs_addr];
    if (tab_we) begin
      c_mem[c_addr] <= c_wdata;
      d_mem[d_addr] <= d_wdata;
    end
    c_rd <= c_mem[c_addr];
    d_rd <= d_mem[d_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_reg <= '0;
      pts       <= '0;
      nearest   <= '0;
      flag_many <= 1'b0;
      flag_dup  <= 1'b0;
      flag_sat  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) order_reg <= cfg_wr_data;
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_LOAD: if (in_acc) begin
          if (pts < CNT_W'(MAX_POINTS)) begin
            if (pts == '0 || x_mag < near_mag) begin
              nearest  <= pts[ROW_W-1:0];
              near_mag <= x_mag;
            end
            pts <= pts + 1'b1;
          end else begin
            flag_many <= 1'b1;
          end
          nd <= (order_reg > K_W'(MAX_DERIV)) ? K_W'(MAX_DERIV) : order_reg;
        end
        ST_INIT_RD: n <= ROW_W'(pts - 1'b1);
        ST_INIT_WB: begin
          for (int q = 1; q < NDER; q++) acc[q] <= '0;
          acc[0] <= c_rd;
          m    <= CNT_W'(1);
          i    <= '0;
          k    <= '0;
          kmax <= (nd == '0) ? '0 : K_W'(1);
          ns   <= NS_W'(nearest) - NS_W'(1);
        end
        ST_XB_RD: dm <= abs_rd;
        ST_K_RD:  if (k == '0) dp <= abs_rd;
        ST_K_NUM: begin
          neg <= num[NUM_W-1] ^ den[DEN_W-1];
          if (den == '0) begin
            xq       <= '0;
            flag_dup <= 1'b1;
          end
        end
        ST_DIV: if (div_done) begin
          xq <= xq_val;
          if (xq_ov) flag_sat <= 1'b1;
        end
        ST_MUL0: prod <= mul_a * mul_b;
        ST_MUL1: begin
          pd_lo <= prod;
          prod  <= mul_a * mul_b;
        end
        ST_MUL2: begin
          pd_hi <= prod;
          prod  <= mul_a * mul_b;
        end
        ST_MUL3: begin
          pm_lo <= prod;
          prod  <= mul_a * mul_b;
        end
        ST_MUL4: pm_hi <= prod;
        ST_QM: begin
          qd <= qd_val;
          qc <= qc_val;
          if (qd_ov || qc_ov) flag_sat <= 1'b1;
        end
        ST_WR: begin
          if (wr_ov) flag_sat <= 1'b1;
          xq_prev <= xq;
          if (k < kmax) begin
            k <= k + 1'b1;
          end else begin
            k <= '0;
            i <= i + 1'b1;
          end
        end
        ST_ACC_SEL: begin
          sel_c <= $signed({ns, 1'b1}) <
                   ($signed({3'b0, n}) - $signed({2'b0, m}));
          j <= ($signed({ns, 1'b1}) < ($signed({3'b0, n}) - $signed({2'b0, m}))) ?
               clamp_row(ns + NS_W'(1)) : clamp_row(ns);
          k <= '0;
        end
        ST_ACC_WB: begin
          acc[k] <= acc_add;
          if (acc_sum[Q_W] != acc_sum[Q_W-1]) flag_sat <= 1'b1;
          if (k < kmax) begin
            k <= k + 1'b1;
          end else begin
            if (!sel_c) ns <= ns - NS_W'(1);
            k    <= '0;
            i    <= '0;
            m    <= m + 1'b1;
            kmax <= (m + 1'b1 > CNT_W'(nd)) ? nd : K_W'(m + 1'b1);
          end
        end
        ST_OUT: if (out_free) begin
          out_valid             <= 1'b1;
          out_data.deriv_index  <= k;
          out_data.result_value <= acc[k];
          out_data.status       <= status;
          out_data.last_result  <= (k == nd);
          if (k == nd) begin
            pts       <= '0;
            nearest   <= '0;
            flag_many <= 1'b0;
            flag_dup  <= 1'b0;
            flag_sat  <= 1'b0;
          end else begin
            k <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/nid_checker.sv
// Port-level checks for the Neville interpolation unit, bound to the top level.
// Depends on nid_pkg and neville_interpolation_with_derivatives_unit.
`default_nettype none
module nid_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input nid_pkg::out_item_t   out_data
);
  import nid_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid survived reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result item changed.");

  a_busy_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_result |-> in_stall)
    else $error("Input accepted while results of a run were still pending.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_result |-> out_data.deriv_index < K_W'(MAX_DERIV))
    else $error("Non-final result carries the highest derivative index.");

endmodule

bind neville_interpolation_with_derivatives_unit nid_checker u_nid_checker (.*);
`default_nettype wire
